@@ sv/mfu_pkg.sv @@
package mfu_pkg;

	// Field widths
	localparam int FRAME_W     = 48;
	localparam int ENC_W       = 17;
	localparam int GEAR_W      = 8;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 17;
	localparam int OUT_DATA_W  = 144;

	// Dividend widths of the angle and speed dividers
	localparam int ANGLE_DIV_W = 44;
	localparam int SPEED_DIV_W = 29;

	// Register reset values
	localparam logic [ENC_W-1:0]  ENC_COUNTS_RST = 17'd8192;
	localparam logic [GEAR_W-1:0] GEAR_RATIO_RST = 8'd19;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ENC  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_GEAR = 8'd1;

	// 360 * 65536 / 8192 for the angle, 2*pi/60 in Q0.32 for the speed
	localparam logic signed [12:0] ANGLE_K = 13'sd2880;
	localparam logic signed [29:0] SPEED_K = 30'sd449767923;

	localparam int QUEUE_DEPTH_DEF = 2;

	// One unpacked and unwrapped frame, handed from front to back
	typedef struct packed {
		logic signed [31:0] total_counts;
		logic signed [15:0] motor_current;
		logic signed [15:0] speed_rpm;
		logic        [15:0] raw_position;
	} mfu_item_t;

endpackage

@@ sv/mfu_front.sv @@
module mfu_front import mfu_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [FRAME_W-1:0]     s_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   push_valid,
	input  logic                   push_ready,
	output mfu_item_t              push_item,
	output logic [GEAR_W-1:0]      gear
);

	logic [ENC_W-1:0]  enc_q;
	logic [GEAR_W-1:0] gear_q;
	logic              primed_q;
	logic [15:0]       last_q;
	logic signed [31:0] sum_q;

	logic [15:0]        pos;
	logic signed [17:0] diff;
	logic signed [18:0] dx, n_s, half_s, adj;
	logic signed [32:0] acc;
	logic signed [31:0] sum_sat, sum_next;
	logic               accept;

	assign cfg_ready  = 1'b1;
	assign s_tready   = push_ready;
	assign accept     = s_tvalid & push_ready;
	assign push_valid = s_tvalid;
	assign gear       = gear_q;
	assign pos        = s_tdata[47:32];

	// Fold the position step into half a turn and add it with saturation
	always_comb begin
		diff   = $signed({2'b00, pos}) - $signed({2'b00, last_q});
		dx     = {diff[17], diff};
		n_s    = $signed({2'b00, enc_q});
		half_s = $signed({3'b000, enc_q[ENC_W-1:1]});
		if (dx > half_s) begin
			adj = dx - n_s;
		end else if (dx < -half_s) begin
			adj = dx + n_s;
		end else begin
			adj = dx;
		end
		acc = {sum_q[31], sum_q} + {{14{adj[18]}}, adj};
		if (acc[32] != acc[31]) begin
			sum_sat = acc[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sum_sat = acc[31:0];
		end
		sum_next = primed_q ? sum_sat : 32'sd0;
	end

	always_comb begin
		push_item.raw_position  = pos;
		push_item.speed_rpm     = s_tdata[31:16];
		push_item.motor_current = s_tdata[15:0];
		push_item.total_counts  = sum_next;
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q  <= ENC_COUNTS_RST;
			gear_q <= GEAR_RATIO_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IDX_ENC:  enc_q  <= cfg_data;
				CFG_IDX_GEAR: gear_q <= cfg_data[GEAR_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance unwrap state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			last_q   <= '0;
			sum_q    <= '0;
		end else if (accept) begin
			primed_q <= 1'b1;
			last_q   <= pos;
			sum_q    <= sum_next;
		end
	end

endmodule

@@ sv/mfu_queue.sv @@
module mfu_queue import mfu_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  mfu_item_t push_item,
	output logic      pop_valid,
	input  logic      pop_ready,
	output mfu_item_t pop_item
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	mfu_item_t       slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/mfu_div.sv @@
module mfu_div import mfu_pkg::*; #(
	parameter int W = ANGLE_DIV_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [W-1:0]      dividend,
	input  logic [GEAR_W-1:0] divisor,
	output logic              busy,
	output logic [W-1:0]      quotient
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]      quo_q;
	logic [GEAR_W-1:0] rem_q, dvs_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [GEAR_W:0]   rem_sh, rem_nx;
	logic              ge;

	assign busy     = busy_q;
	assign quotient = quo_q;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh = {rem_q, quo_q[W-1]};
		ge     = (rem_sh >= {1'b0, dvs_q});
		rem_nx = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= rem_nx[GEAR_W-1:0];
		end
	end

endmodule

@@ sv/mfu_back.sv @@
module mfu_back import mfu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  mfu_item_t             pop_item,
	input  logic [GEAR_W-1:0]     gear,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} state_t;

	state_t             state_q;
	mfu_item_t          item_s1;
	logic signed [43:0] ang_prod_s1;
	logic signed [44:0] spd_prod_s1;
	logic               ang_neg_s2, spd_neg_s2;

	mfu_item_t          out_item_q;
	logic signed [31:0] angle_q, speed_q;
	logic               out_valid_q;

	logic signed [44:0] ang_full;
	logic signed [45:0] spd_full;
	logic [GEAR_W-1:0]  gear_eff;
	logic [43:0]        ang_mag, ang_dvd;
	logic [44:0]        spd_mag, spd_sum;
	logic [SPEED_DIV_W-1:0] spd_dvd, spd_quo;
	logic [ANGLE_DIV_W-1:0] ang_quo;
	logic               div_start, ang_busy, spd_busy, finish;
	logic signed [31:0] angle_res, speed_res;

	assign gear_eff  = (gear == '0) ? GEAR_W'(1) : gear;
	assign pop_ready = (state_q == ST_IDLE);
	assign div_start = (state_q == ST_MUL);
	assign finish    = (state_q == ST_DIV) && !ang_busy && !spd_busy &&
		(!out_valid_q || m_tready);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {speed_q, angle_q, out_item_q.total_counts,
		out_item_q.motor_current, out_item_q.speed_rpm, out_item_q.raw_position};

	// Scale by the angle and speed constants
	assign ang_full = pop_item.total_counts * ANGLE_K;
	assign spd_full = pop_item.speed_rpm * SPEED_K;

	// Take magnitudes and add the rounding half of each divisor
	always_comb begin
		ang_mag = ang_prod_s1[43] ? (~ang_prod_s1 + 44'd1) : ang_prod_s1;
		ang_dvd = ang_mag + 44'(gear_eff >> 1);
		spd_mag = spd_prod_s1[44] ? (~spd_prod_s1 + 45'd1) : spd_prod_s1;
		spd_sum = spd_mag + 45'({gear_eff, 15'd0});
		spd_dvd = spd_sum[16 +: SPEED_DIV_W];
	end

	mfu_div #(.W(ANGLE_DIV_W)) u_ang_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ang_dvd),
		.divisor  (gear_eff),
		.busy     (ang_busy),
		.quotient (ang_quo)
	);

	mfu_div #(.W(SPEED_DIV_W)) u_spd_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (spd_dvd),
		.divisor  (gear_eff),
		.busy     (spd_busy),
		.quotient (spd_quo)
	);

	// Restore signs and saturate the angle to Q16.16 range
	always_comb begin
		if (!ang_neg_s2) begin
			angle_res = (ang_quo[43:31] != '0) ? 32'sh7FFF_FFFF : {1'b0, ang_quo[30:0]};
		end else if (ang_quo > 44'h0_8000_0000) begin
			angle_res = 32'sh8000_0000;
		end else begin
			angle_res = ~ang_quo[31:0] + 32'd1;
		end
		speed_res = spd_neg_s2 ? (~{3'b000, spd_quo} + 32'd1) : {3'b000, spd_quo};
	end

	// Hold state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			item_s1     <= pop_item;
			ang_prod_s1 <= ang_full[43:0];
			spd_prod_s1 <= spd_full[44:0];
		end
		if (div_start) begin
			ang_neg_s2 <= ang_prod_s1[43];
			spd_neg_s2 <= spd_prod_s1[44];
		end
		if (finish) begin
			out_item_q <= item_s1;
			angle_q    <= angle_res;
			speed_q    <= speed_res;
		end
	end

	a_idle_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !ang_busy && !spd_busy)
		else $error("divider busy while back end idle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |=> ang_busy && spd_busy)
		else $error("dividers did not start");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (speed_q[31:28] == 4'b0000 || speed_q[31:28] == 4'b1111))
		else $error("output speed out of reachable range");

endmodule

@@ sv/motor_feedback_unwrap.sv @@
// Motor feedback unwrap. Each input transaction carries the first six bytes of a
// feedback frame (byte 0 in the top bits). The front end unpacks position, speed and
// current and unwraps the position into a saturating 32-bit position count in the
// accept cycle; the first frame after reset primes the counter at zero. Up to
// QUEUE_DEPTH unwrapped frames wait in a queue for the back end, which scales them
// and divides angle and speed by the gear ratio with two bit-serial dividers, one
// quotient bit per cycle. An item passes through the back end in order: it is taken
// from the queue and scaled, the dividers are loaded, 44 angle division steps run and
// the result is registered, which waits while an earlier result is stalled at the
// output. No new item is taken until then. Configuration writes (index 0: encoder
// counts, index 1: gear ratio) are always taken.
module motor_feedback_unwrap import mfu_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// frame_head [47:0]
	input  logic [FRAME_W-1:0]     s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// raw_position [15:0], speed_rpm [31:16], motor_current [47:32],
	// total_counts [79:48], output_angle [111:80], output_speed [143:112]
	output logic [OUT_DATA_W-1:0]  m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic              push_valid, push_ready, pop_valid, pop_ready;
	mfu_item_t         push_item, pop_item;
	logic [GEAR_W-1:0] gear;

	mfu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.gear       (gear)
	);

	mfu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	mfu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.gear      (gear),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
